// ===== hdl/rans_pkg.sv =====
// rans encoder package: sizes, action and result codes, register indexes
// no dependencies
`default_nettype none
package rans_pkg;
	localparam int NUM_SYMBOLS = 256;
	localparam int SYM_W       = $clog2(NUM_SYMBOLS);
	localparam int CNT_W       = SYM_W + 1;
	localparam int LOG_M_MAX   = 12;
	localparam int FREQ_W      = 13;
	localparam int MAX_DIGITS  = 16;
	localparam int STATE_W     = 32;
	localparam int DIGIT_W     = 16;
	localparam int K_W         = 16;
	localparam int LB_W        = 5;
	localparam int PROD_W      = STATE_W + FREQ_W;
	localparam int WIDE_W      = 48;

	localparam logic [2:0] ACT_CLEAR  = 3'd0;
	localparam logic [2:0] ACT_APPEND = 3'd1;
	localparam logic [2:0] ACT_BEGIN  = 3'd2;
	localparam logic [2:0] ACT_ENCODE = 3'd3;
	localparam logic [2:0] ACT_FINISH = 3'd4;

	localparam logic [1:0] KIND_DIGIT = 2'd0;
	localparam logic [1:0] KIND_STATE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] REG_DIGIT_LOG2 = 2'd0;
	localparam logic [1:0] REG_K_MULT     = 2'd1;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [FREQ_W-1:0] start;
	} tbl_entry_t;
endpackage
`default_nettype wire

// ===== hdl/rans_ifs.sv =====
// channel interfaces of the rans encoder: input words, result words, config writes
// depends on rans_pkg
`default_nettype none
interface rans_in_if import rans_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        action;
	logic [SYM_W-1:0]  symbol;
	logic [FREQ_W-1:0] freq;
	modport source (output valid, action, symbol, freq, input ready);
	modport sink (input valid, action, symbol, freq, output ready);
endinterface

interface rans_out_if import rans_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [DIGIT_W-1:0] digit;
	logic [STATE_W-1:0] state_value;
	logic               last;
	modport source (output valid, kind, digit, state_value, last, input ready);
	modport sink (input valid, kind, digit, state_value, last, output ready);
endinterface

interface rans_cfg_if import rans_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/rans_encoder_core.sv =====
// rANS encoder top level: table memory, renormalisation, division and result sequencer
// depends on rans_pkg and the channel interfaces in rans_ifs.sv
// One word is handled at a time. Clear and a good append are done at the accept; begin
// adds a range check. Finish and errors hand over a single result word. An encode word
// goes through the accept, one memory read with the k*F multiply, a renormalisation
// check, the bit-serial divider, a multiply and a check. Each emitted digit adds one
// renormalisation step and one hand-off step, and the result side can stall a hand-off.
// The restoring divider takes the bulk of an encode word's time. Config writes are
// always taken and take effect at once, also on a word in progress.
`default_nettype none
module rans_encoder_core import rans_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	rans_in_if.sink    req,
	rans_out_if.source rsp,
	rans_cfg_if.sink   cfg
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_REN  = 4'd2;
	localparam logic [3:0] ST_DIV  = 4'd3;
	localparam logic [3:0] ST_NMUL = 4'd4;
	localparam logic [3:0] ST_CHK  = 4'd5;
	localparam logic [3:0] ST_EMIT = 4'd6;
	localparam logic [3:0] ST_ONE  = 4'd7;
	localparam logic [3:0] ST_BEG  = 4'd8;

	logic [3:0]         state_q;
	logic [LB_W-1:0]    dlog_q;
	logic [K_W-1:0]     kmul_q;
	logic [FREQ_W-1:0]  total_q;
	logic [CNT_W-1:0]   count_q;
	logic [STATE_W-1:0] coder_q;
	logic [STATE_W-1:0] x_q;
	logic [4:0]         n_q;
	logic [4:0]         dcnt_q;
	logic [FREQ_W-1:0]  rem_q;
	logic [PROD_W-1:0]  prod_q;
	logic [1:0]         one_kind_q;
	tbl_entry_t         rd_q;
	tbl_entry_t         ent_q;
	tbl_entry_t         tbl_mem [NUM_SYMBOLS];

	logic               out_valid_q;
	logic [1:0]         out_kind_q;
	logic [DIGIT_W-1:0] out_digit_q;
	logic [STATE_W-1:0] out_state_q;
	logic               out_last_q;

	logic [LB_W-1:0]    lb;
	logic [K_W-1:0]     keff;
	logic [WIDE_W-1:0]  wide_sh;
	logic [DIGIT_W:0]   dmask;
	logic               slot_free;
	logic               load_out;
	logic               acc;
	logic [FREQ_W:0]    div_cand;
	logic [FREQ_W:0]    app_sum;
	logic [PROD_W:0]    nx;

	always_comb begin
		if (dlog_q == '0) lb = LB_W'(1);
		else if (dlog_q > LB_W'(16)) lb = LB_W'(16);
		else lb = dlog_q;
		keff = (kmul_q == '0) ? K_W'(1) : kmul_q;
		// b*k*F or b*k*M from the registered product
		wide_sh = {{(WIDE_W-PROD_W){1'b0}}, prod_q} << lb;
		dmask = (DIGIT_W+1)'((17'd1 << lb) - 17'd1);
		div_cand = {rem_q, x_q[STATE_W-1]};
		app_sum = {1'b0, total_q} + {1'b0, req.freq};
		nx = {1'b0, prod_q} + (PROD_W+1)'(ent_q.start) + (PROD_W+1)'(rem_q);
	end

	assign slot_free = !out_valid_q || rsp.ready;
	assign load_out = slot_free && (state_q == ST_EMIT || state_q == ST_ONE);
	assign req.ready = (state_q == ST_IDLE);
	assign acc = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid = out_valid_q;
	assign rsp.kind = out_kind_q;
	assign rsp.digit = out_digit_q;
	assign rsp.state_value = out_state_q;
	assign rsp.last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlog_q <= LB_W'(8);
			kmul_q <= K_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DIGIT_LOG2: dlog_q <= cfg.data[LB_W-1:0];
				REG_K_MULT:     kmul_q <= cfg.data[K_W-1:0];
				default: ;
			endcase
		end
	end

	// table memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (acc && req.action == ACT_APPEND && !count_q[CNT_W-1]
				&& app_sum <= (FREQ_W+1)'(1 << LOG_M_MAX))
			tbl_mem[count_q[SYM_W-1:0]] <= '{freq: req.freq, start: total_q};
		rd_q <= tbl_mem[req.symbol];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
			count_q <= '0;
			coder_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && !rsp.ready);
			unique case (state_q)
				ST_IDLE: if (acc) begin
					one_kind_q <= (req.action == ACT_FINISH) ? KIND_STATE : KIND_ERROR;
					case (req.action)
						ACT_CLEAR: begin
							total_q <= '0;
							count_q <= '0;
						end
						ACT_APPEND: begin
							if (count_q[CNT_W-1] || app_sum > (FREQ_W+1)'(1 << LOG_M_MAX))
								state_q <= ST_ONE;
							else begin
								total_q <= app_sum[FREQ_W-1:0];
								count_q <= count_q + CNT_W'(1);
							end
						end
						ACT_BEGIN: begin
							prod_q <= PROD_W'(keff) * PROD_W'(total_q);
							state_q <= ST_BEG;
						end
						ACT_ENCODE: begin
							x_q <= coder_q;
							n_q <= '0;
							state_q <= (CNT_W'(req.symbol) >= count_q) ? ST_ONE : ST_RD;
						end
						ACT_FINISH: begin
							state_q <= ST_ONE;
						end
						default: state_q <= ST_ONE;
					endcase
				end
				ST_BEG: begin
					if (total_q == '0 || wide_sh[WIDE_W-1:STATE_W] != '0)
						state_q <= ST_ONE;
					else begin
						coder_q <= prod_q[STATE_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					ent_q <= rd_q;
					prod_q <= PROD_W'(keff) * PROD_W'(rd_q.freq);
					state_q <= (rd_q.freq == '0) ? ST_ONE : ST_REN;
				end
				ST_REN: begin
					if ({{(WIDE_W-STATE_W){1'b0}}, x_q} >= wide_sh) begin
						if (n_q == 5'(MAX_DIGITS)) state_q <= ST_ONE;
						else begin
							x_q <= x_q >> lb;
							n_q <= n_q + 5'd1;
						end
					end else begin
						rem_q <= '0;
						dcnt_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit a cycle
					if (div_cand >= {1'b0, ent_q.freq}) begin
						rem_q <= FREQ_W'(div_cand - {1'b0, ent_q.freq});
						x_q <= {x_q[STATE_W-2:0], 1'b1};
					end else begin
						rem_q <= div_cand[FREQ_W-1:0];
						x_q <= {x_q[STATE_W-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd31) state_q <= ST_NMUL;
				end
				ST_NMUL: begin
					prod_q <= PROD_W'(x_q) * PROD_W'(total_q);
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (nx[PROD_W:STATE_W] != '0) state_q <= ST_ONE;
					else begin
						x_q <= coder_q;
						coder_q <= nx[STATE_W-1:0];
						dcnt_q <= n_q;
						state_q <= (n_q == '0) ? ST_IDLE : ST_EMIT;
					end
				end
				ST_EMIT: if (slot_free) begin
					out_kind_q <= KIND_DIGIT;
					out_digit_q <= x_q[DIGIT_W-1:0] & dmask[DIGIT_W-1:0];
					out_state_q <= '0;
					out_last_q <= (dcnt_q == 5'd1);
					x_q <= x_q >> lb;
					dcnt_q <= dcnt_q - 5'd1;
					if (dcnt_q == 5'd1) state_q <= ST_IDLE;
				end
				ST_ONE: if (slot_free) begin
					out_kind_q <= one_kind_q;
					out_digit_q <= '0;
					out_state_q <= (one_kind_q == KIND_STATE) ? coder_q : '0;
					out_last_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_emit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> dcnt_q != '0)
		else $error("digit emission with empty count");
	a_coder_upd: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(coder_q) |-> $past(state_q == ST_CHK || state_q == ST_BEG))
		else $error("coder state changed outside commit");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NUM_SYMBOLS))
		else $error("table count beyond table size");
	a_enc_path: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.action == ACT_ENCODE |=> state_q == ST_RD || state_q == ST_ONE)
		else $error("encode word took wrong path");
`endif
endmodule
`default_nettype wire

// ===== tb/rans_encoder_core_tb.sv =====
// self-checking testbench for rans_encoder_core: table loading, stream begin, encode, finish
// depends on rans_pkg and the channel interfaces in hdl/rans_ifs.sv
`default_nettype none
module rans_encoder_core_tb;
	import rans_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ACT_UNDEF_LO = 3'd5;
	localparam logic [2:0] ACT_UNDEF_HI = 3'd7;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 80;
	localparam int RAND_WORDS = 20;

	typedef struct packed {
		logic [1:0]         kind;
		logic [DIGIT_W-1:0] digit;
		logic [STATE_W-1:0] state_value;
		logic               last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rans_in_if  req_if ();
	rans_out_if rsp_if ();
	rans_cfg_if cfg_if ();

	rans_encoder_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source),
		.cfg    (cfg_if.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the encoder
	logic [FREQ_W-1:0]  sh_freq [NUM_SYMBOLS];
	logic [FREQ_W-1:0]  sh_start [NUM_SYMBOLS];
	int unsigned        sh_total;
	int unsigned        sh_count;
	logic [STATE_W-1:0] sh_state;
	logic [4:0]         sh_lb;
	logic [15:0]        sh_k;

	result_t expected_q[$];
	int      mismatches = 0;
	int      words_sent = 0;
	int      cycles = 0;
	bit      no_idle = 0;

	task automatic push_result(input logic [1:0] kind, input logic [DIGIT_W-1:0] dg,
			input logic [STATE_W-1:0] st, input logic last);
		result_t r;
		r.kind = kind;
		r.digit = dg;
		r.state_value = st;
		r.last = last;
		expected_q.insert(expected_q.size(), r);
	endtask

	task automatic predict_word(input logic [2:0] act, input logic [7:0] sym,
			input logic [12:0] fq);
		int unsigned lb;
		longint unsigned b, k, f, bound, x, nx;
		int n;
		lb = (sh_lb == 0) ? 1 : ((sh_lb > 16) ? 16 : sh_lb);
		b = 64'd1 << lb;
		k = (sh_k == 0) ? 1 : sh_k;
		n = 0;
		case (act)
			ACT_CLEAR: begin
				sh_total = 0;
				sh_count = 0;
			end
			ACT_APPEND: begin
				if (sh_count >= NUM_SYMBOLS || sh_total + fq > (1 << LOG_M_MAX))
					push_result(KIND_ERROR, '0, '0, 1'b1);
				else begin
					sh_freq[sh_count] = fq;
					sh_start[sh_count] = FREQ_W'(sh_total);
					sh_total += fq;
					sh_count++;
				end
			end
			ACT_BEGIN: begin
				if (sh_total == 0 || b * k * sh_total >= 64'h1_0000_0000)
					push_result(KIND_ERROR, '0, '0, 1'b1);
				else
					sh_state = STATE_W'(k * sh_total);
			end
			ACT_ENCODE: begin
				if (sym >= sh_count || sh_freq[sym] == 0) begin
					push_result(KIND_ERROR, '0, '0, 1'b1);
					return;
				end
				f = sh_freq[sym];
				bound = b * k * f;
				x = sh_state;
				while (x >= bound) begin
					if (n >= MAX_DIGITS) begin
						push_result(KIND_ERROR, '0, '0, 1'b1);
						return;
					end
					n++;
					x >>= lb;
				end
				nx = (x / f) * sh_total + sh_start[sym] + (x % f);
				if (nx >= 64'h1_0000_0000) begin
					push_result(KIND_ERROR, '0, '0, 1'b1);
					return;
				end
				x = sh_state;
				for (int i = 0; i < n; i++) begin
					push_result(KIND_DIGIT, DIGIT_W'(x & (b - 1)), '0, i == n - 1);
					x >>= lb;
				end
				sh_state = STATE_W'(nx);
			end
			ACT_FINISH: push_result(KIND_STATE, '0, sh_state, 1'b1);
			default: push_result(KIND_ERROR, '0, '0, 1'b1);
		endcase
	endtask

	// one input word: random gap, then hold valid until taken
	task automatic send_word(input logic [2:0] act, input logic [7:0] sym,
			input logic [12:0] fq);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.action <= act;
		req_if.symbol <= sym;
		req_if.freq <= fq;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		predict_word(act, sym, fq);
		words_sent++;
	endtask

	// wait until every expected word is back and the block has settled
	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		drain();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		if (idx == REG_DIGIT_LOG2)
			sh_lb = value[4:0];
		else if (idx == REG_K_MULT)
			sh_k = value[15:0];
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// result side: random stall per word
	initial begin
		int stall;
		rsp_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_if.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: kind %0d digit %h state %h last %b",
						rsp_if.kind, rsp_if.digit, rsp_if.state_value, rsp_if.last);
			end else begin
				want = expected_q.pop_front();
				if (want.kind !== rsp_if.kind || want.digit !== rsp_if.digit ||
						want.state_value !== rsp_if.state_value ||
						want.last !== rsp_if.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp kind %0d digit %h state %h last %b, %s",
							want.kind, want.digit, want.state_value, want.last,
							$sformatf("got kind %0d digit %h state %h last %b",
							rsp_if.kind, rsp_if.digit, rsp_if.state_value,
							rsp_if.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("rans_encoder_core verification failed");
			$finish;
		end
	end

	// errors with no table, undefined actions, empty begin
	task automatic test_empty_table();
		send_word(ACT_ENCODE, 8'd0, '0);
		send_word(ACT_FINISH, 8'd0, '0);
		send_word(ACT_BEGIN, 8'd0, '0);
		for (int a = ACT_UNDEF_LO; a <= ACT_UNDEF_HI; a++)
			send_word(3'(a), 8'hff, 13'h1fff);
	endtask

	// small table with a zero entry, extremes of symbol and freq
	task automatic test_small_stream();
		send_word(ACT_CLEAR, '0, '0);
		send_word(ACT_APPEND, '0, 13'd3);
		send_word(ACT_APPEND, '0, 13'd0);
		send_word(ACT_APPEND, '0, 13'd5);
		send_word(ACT_APPEND, '0, 13'd4096);
		send_word(ACT_APPEND, '0, 13'h1fff);
		send_word(ACT_BEGIN, '0, '0);
		send_word(ACT_ENCODE, 8'd1, '0);
		send_word(ACT_ENCODE, 8'd3, '0);
		send_word(ACT_ENCODE, 8'd255, '0);
		for (int i = 0; i < 6; i++)
			send_word(ACT_ENCODE, (i & 1) ? 8'd2 : 8'd0, '0);
		send_word(ACT_FINISH, '0, '0);
	endtask

	// a full table: 256 entries of 16 reach 4096 exactly, then one more
	task automatic test_full_table();
		send_word(ACT_CLEAR, '0, '0);
		for (int i = 0; i < NUM_SYMBOLS; i++)
			send_word(ACT_APPEND, '0, 13'd16);
		send_word(ACT_APPEND, '0, 13'd0);
		send_word(ACT_BEGIN, '0, '0);
		send_word(ACT_ENCODE, 8'd255, '0);
		send_word(ACT_ENCODE, 8'd128, '0);
		send_word(ACT_FINISH, '0, '0);
	endtask

	// begin overflow, state out of its interval, encode overflow
	task automatic test_range_errors();
		write_reg(REG_DIGIT_LOG2, 32'd16);
		write_reg(REG_K_MULT, 32'd65535);
		send_word(ACT_CLEAR, '0, '0);
		send_word(ACT_APPEND, '0, 13'd1);
		send_word(ACT_APPEND, '0, 13'd4095);
		send_word(ACT_BEGIN, '0, '0);
		write_reg(REG_DIGIT_LOG2, 32'd4);
		send_word(ACT_BEGIN, '0, '0);
		write_reg(REG_DIGIT_LOG2, 32'd16);
		send_word(ACT_ENCODE, 8'd0, '0);
		write_reg(REG_DIGIT_LOG2, 32'd1);
		write_reg(REG_K_MULT, 32'd1);
		send_word(ACT_ENCODE, 8'd1, '0);
		send_word(ACT_FINISH, '0, '0);
		// out-of-range register values
		write_reg(REG_DIGIT_LOG2, 32'hffff_ffe0);
		write_reg(REG_K_MULT, 32'hffff_0000);
		send_word(ACT_ENCODE, 8'd1, '0);
		write_reg(REG_DIGIT_LOG2, 32'd31);
		send_word(ACT_ENCODE, 8'd0, '0);
		send_word(ACT_FINISH, '0, '0);
	endtask

	// the sender holds off until everything has come back
	task automatic test_hold_off();
		drain();
		send_word(ACT_FINISH, '0, '0);
	endtask

	// well-formed streams with random content, some noise and broken sequences
	task automatic test_random_streams();
		int n, m, total, room, target;
		target = words_sent + RAND_WORDS;
		while (words_sent < target) begin
			no_idle = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_DIGIT_LOG2, $urandom());
			else
				write_reg(REG_DIGIT_LOG2, $urandom_range(1, 16));
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_K_MULT, $urandom());
			else
				write_reg(REG_K_MULT, $urandom_range(0, 8));
			send_word(ACT_CLEAR, '0, '0);
			n = $urandom_range(1, 8);
			total = 0;
			for (int i = 0; i < n; i++) begin
				room = (4096 - total) / (n - i);
				if ($urandom_range(0, 9) == 0)
					send_word(ACT_APPEND, 8'($urandom()), 13'($urandom()));
				else
					send_word(ACT_APPEND, 8'($urandom()),
						($urandom_range(0, 7) == 0) ? 13'd0 : 13'($urandom_range(0, room)));
				total = sh_total;
			end
			send_word(ACT_BEGIN, 8'($urandom()), 13'($urandom()));
			m = $urandom_range(2, 10);
			for (int i = 0; i < m; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_word(3'($urandom()), 8'($urandom()), 13'($urandom()));
				else
					send_word(ACT_ENCODE, 8'($urandom_range(0, n - 1)), 13'($urandom()));
			end
			send_word(ACT_FINISH, 8'($urandom()), 13'($urandom()));
		end
		no_idle = 0;
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.action = ACT_CLEAR;
		req_if.symbol = '0;
		req_if.freq = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_DIGIT_LOG2;
		cfg_if.data = '0;
		sh_total = 0;
		sh_count = 0;
		sh_state = '0;
		sh_lb = 5'd8;
		sh_k = 16'd1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_small_stream();
		test_hold_off();
		test_full_table();
		test_range_errors();
		test_random_streams();
		drain();
		if (mismatches == 0)
			$display("rans_encoder_core verification clean");
		else
			$display("rans_encoder_core verification failed");
		$finish;
	end
endmodule
`default_nettype wire
